// ===== sv/sidb_pkg.sv =====
// Shared types and constants for the sequence insert/delete buffer.
// No dependencies; every other file of the block imports this package.
package sidb_pkg;

	localparam int MAX_LEN = 8192;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int LEN_W   = $clog2(MAX_LEN + 1);
	localparam int FIELD_W = 14;
	localparam int VALUE_W = 20;
	// width that holds both a port field and an internal length for compares
	localparam int CMP_W   = (LEN_W > FIELD_W) ? LEN_W : FIELD_W;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_APPEND = 2'd2,
		ACT_READ   = 2'd3
	} act_t;

	typedef struct packed {
		act_t               action;
		logic [FIELD_W-1:0] position;
		logic [FIELD_W-1:0] count;
		logic [VALUE_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic [FIELD_W-1:0] length;
		logic               error;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic decide;
		logic shift;
		logic commit;
		logic load_result;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic moves_nz;
	} status_t;

endpackage

// ===== sv/sidb_in_if.sv =====
// Input channel of the sequence buffer: valid/ready handshake plus one action word.
// Depends on sidb_pkg for the word type.
interface sidb_in_if;
	import sidb_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/sidb_out_if.sv =====
// Result channel of the sequence buffer: valid/ready handshake plus one result word.
// Depends on sidb_pkg for the word type.
interface sidb_out_if;
	import sidb_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/sidb_ctrl.sv =====
// Sequencing state machine of the sequence buffer: handshakes and datapath commands.
// Depends on sidb_pkg for the command and status structs.
module sidb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sidb_pkg::status_t status,
	output sidb_pkg::cmd_t    cmd
);
	import sidb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SHIFT,
		ST_COMMIT,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   load;

	assign load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.capture     = (state_q == ST_IDLE) && in_valid;
		cmd.decide      = (state_q == ST_DECIDE);
		cmd.shift       = (state_q == ST_SHIFT);
		cmd.commit      = (state_q == ST_COMMIT);
		cmd.load_result = load;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (!status.moves_nz) state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/sidb_dpath.sv =====
// Datapath of the sequence buffer: element memory, length, shift counters, result register.
// Depends on sidb_pkg; driven by commands from sidb_ctrl.
module sidb_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  sidb_pkg::in_word_t  in_data,
	input  sidb_pkg::cmd_t      cmd,
	output sidb_pkg::status_t   status,
	output sidb_pkg::out_word_t out_data
);
	import sidb_pkg::*;

	logic [VALUE_W-1:0] mem [MAX_LEN];

	act_t               act_q;
	logic [FIELD_W-1:0] pos_q;
	logic [FIELD_W-1:0] cnt_q;
	logic [VALUE_W-1:0] val_q;
	logic [LEN_W-1:0]   len_q;
	logic               err_q;
	logic [LEN_W-1:0]   n_q;
	logic [LEN_W-1:0]   moves_q;
	logic [ADDR_W-1:0]  rd_addr_q;
	logic [VALUE_W-1:0] rd_data_s1;
	logic               wr_valid_s1;
	logic [ADDR_W-1:0]  wr_addr_s1;
	out_word_t          out_q;

	logic [CMP_W-1:0]   pos_c, len_c, cnt_c, avail, del_n, del_moves;
	logic               pos_gt, full, cnt_lt;
	logic               err_d;
	logic [LEN_W-1:0]   moves_d, n_d;
	logic [ADDR_W-1:0]  rd_addr_d;
	logic               moves_nz, rd_en, wr_en, commit_wr;
	logic [ADDR_W-1:0]  wr_addr;
	logic [VALUE_W-1:0] wr_data;

	// Classify the held action against the current length.
	always_comb begin
		pos_c     = CMP_W'(pos_q);
		len_c     = CMP_W'(len_q);
		cnt_c     = CMP_W'(cnt_q);
		pos_gt    = pos_c > len_c;
		full      = len_q == LEN_W'(MAX_LEN);
		avail     = len_c - pos_c;
		cnt_lt    = cnt_c < avail;
		del_n     = cnt_lt ? cnt_c : avail;
		del_moves = cnt_lt ? (avail - cnt_c) : '0;
		err_d     = 1'b0;
		moves_d   = '0;
		n_d       = '0;
		rd_addr_d = '0;
		unique case (act_q)
			ACT_INSERT: begin
				err_d     = pos_gt || full;
				moves_d   = err_d ? '0 : LEN_W'(avail);
				rd_addr_d = ADDR_W'(len_q - LEN_W'(1));
			end
			ACT_DELETE: begin
				err_d     = pos_gt;
				moves_d   = err_d ? '0 : LEN_W'(del_moves);
				n_d       = LEN_W'(del_n);
				rd_addr_d = ADDR_W'(pos_c + cnt_c);
			end
			ACT_APPEND: begin
				err_d = full;
			end
			ACT_READ: begin
				err_d     = !(pos_c < len_c);
				rd_addr_d = ADDR_W'(pos_q);
			end
			default: begin
				err_d = 1'b1;
			end
		endcase
	end

	assign moves_nz        = moves_q != '0;
	assign status.moves_nz = moves_nz;

	// One memory read per cycle: a shift move or the element of a read action.
	assign rd_en = (cmd.shift && moves_nz) ||
		(cmd.commit && (act_q == ACT_READ) && !err_q);

	// One memory write per cycle: the tail of a move, else the new element.
	assign commit_wr = cmd.commit && !err_q &&
		((act_q == ACT_INSERT) || (act_q == ACT_APPEND));
	assign wr_en   = wr_valid_s1 || commit_wr;
	assign wr_addr = wr_valid_s1 ? wr_addr_s1 :
		((act_q == ACT_INSERT) ? ADDR_W'(pos_q) : ADDR_W'(len_q));
	assign wr_data = wr_valid_s1 ? rd_data_s1 : val_q;

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_s1 <= mem[rd_addr_q];
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			wr_valid_s1 <= 1'b0;
		end else begin
			wr_valid_s1 <= cmd.shift && moves_nz;
			if (cmd.commit && !err_q) begin
				case (act_q)
					ACT_INSERT, ACT_APPEND: len_q <= len_q + LEN_W'(1);
					ACT_DELETE:             len_q <= len_q - n_q;
					default:                len_q <= len_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= in_data.action;
			pos_q <= in_data.position;
			cnt_q <= in_data.count;
			val_q <= in_data.value;
		end
		if (cmd.decide) begin
			err_q     <= err_d;
			moves_q   <= moves_d;
			n_q       <= n_d;
			rd_addr_q <= rd_addr_d;
		end else if (cmd.shift && moves_nz) begin
			moves_q <= moves_q - LEN_W'(1);
			if (act_q == ACT_INSERT) begin
				wr_addr_s1 <= rd_addr_q + ADDR_W'(1);
				rd_addr_q  <= rd_addr_q - ADDR_W'(1);
			end else begin
				wr_addr_s1 <= rd_addr_q - ADDR_W'(n_q);
				rd_addr_q  <= rd_addr_q + ADDR_W'(1);
			end
		end
		if (cmd.load_result) begin
			out_q.read_value <= ((act_q == ACT_READ) && !err_q) ? rd_data_s1 : '0;
			out_q.length     <= FIELD_W'(len_q);
			out_q.error      <= err_q;
		end
	end

	assign out_data = out_q;

endmodule

// ===== sv/sequence_insert_delete_buffer_core.sv =====
// Sequence insert/delete buffer: an ordered list of up to MAX_LEN 20-bit elements.
// For each accepted action word the block decides, shifts moves elements, commits and loads
// the result; moves is the number of elements shifted (insert: length-position, delete:
// elements behind the removed run, zero for append, read and rejected actions).
// A new action is taken once the last result is loaded; the single element memory moves one
// element per cycle. Reset clears the length and the handshakes; memory keeps its contents.
module sequence_insert_delete_buffer_core (
	input  logic              clk,
	input  logic              arst_n,
	sidb_in_if.sink           item,
	sidb_out_if.source        result
);
	import sidb_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer: accept one word, walk the datapath through decide, shift and
	// commit, then hold the result in the output register until taken. A new
	// word is accepted while the previous result still waits downstream.
	sidb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: insert moves elements upward from the tail, delete moves them
	// down from behind the removed run; each move reads one address and writes
	// the element back in the next cycle at its new place.
	sidb_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (item.data),
		.cmd      (cmd),
		.status   (status),
		.out_data (result.data)
	);

endmodule

// ===== bench/sidb_bench_pkg.sv =====
// Scoreboard for the sequence buffer bench: mirrors the element list and queues result words.
// Depends on sidb_pkg for the word types, the action codes and MAX_LEN.
package sidb_bench_pkg;
	import sidb_pkg::*;

	class seq_mirror;
		logic [VALUE_W-1:0] elems[$];
		out_word_t          expected_results[$];
		int                 mismatches = 0;

		// Apply one accepted action word to the mirror and queue its result word.
		function void note_action(in_word_t w);
			out_word_t want;
			int        len;
			int        pos;
			int        n;
			want = '0;
			len  = elems.size();
			pos  = int'(w.position);
			case (w.action)
				ACT_INSERT: begin
					if (pos > len || len >= MAX_LEN) begin
						want.error = 1'b1;
					end else begin
						elems.insert(pos, w.value);
					end
				end
				ACT_DELETE: begin
					if (pos > len) begin
						want.error = 1'b1;
					end else begin
						// saturate at the tail
						n = (int'(w.count) < len - pos) ? int'(w.count) : len - pos;
						repeat (n) elems.delete(pos);
					end
				end
				ACT_APPEND: begin
					if (len >= MAX_LEN) begin
						want.error = 1'b1;
					end else begin
						elems.insert(elems.size(), w.value);
					end
				end
				default: begin
					if (pos >= len) begin
						want.error = 1'b1;
					end else begin
						want.read_value = elems[pos];
					end
				end
			endcase
			want.length = FIELD_W'(elems.size());
			expected_results.insert(expected_results.size(), want);
		endfunction

		task check_result(out_word_t got);
			out_word_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected word", got, '0);
				return;
			end
			want = expected_results.pop_front();
			if (got.read_value !== want.read_value) report_mismatch("read_value", got, want);
			if (got.length !== want.length) report_mismatch("length", got, want);
			if (got.error !== want.error) report_mismatch("error", got, want);
		endtask

		task report_mismatch(string what, out_word_t got, out_word_t want);
			mismatches++;
			$display("%0t bad %s: got %0d/%0d/%b want %0d/%0d/%b", $time, what,
				got.read_value, got.length, got.error,
				want.read_value, want.length, want.error);
		endtask
	endclass

endpackage

// ===== bench/tb.sv =====
// Top-level bench for sequence_insert_delete_buffer_core: drives action words, checks results.
// Depends on sidb_pkg, sidb_in_if, sidb_out_if and sidb_bench_pkg (seq_mirror scoreboard).
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sidb_pkg::*;
	import sidb_bench_pkg::*;

	localparam int ITEMS    = 265;
	localparam int ALL_ONES = 16383;  // every bit of a 14-bit field set
	localparam int SETTLE   = 100;    // covers the longest shift seen in the random part

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sidb_in_if  item_ch();
	sidb_out_if result_ch();

	sequence_insert_delete_buffer_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	seq_mirror mirror = new;

	int gap_max     = 0;  // longest sender gap between bursts; 0 runs back to back
	int burst_left  = 0;
	int hold_cycles = 0;  // long receiver hold-off, counted down by the receiver
	int words_sent  = 0;

	always #5 clk = ~clk;

	// Check every result word taken at a rising edge against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			mirror.check_result(result_ch.data);
	end

	// Receiver: stall in phases of random length and density, and honor a long hold-off
	// when the stimulus asks for one.
	initial begin
		int phase_left;
		int stall_pct;
		phase_left      = 0;
		stall_pct       = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 300);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			phase_left--;
			if (hold_cycles > 0) begin
				hold_cycles--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Offer one action word and hold it until the block takes it. Words go out in bursts;
	// a gap, when one falls, drops valid before the next burst.
	task automatic send_action(act_t a, int pos, int cnt, int val);
		in_word_t w;
		int       gap;
		w.action   = a;
		w.position = pos[FIELD_W-1:0];
		w.count    = cnt[FIELD_W-1:0];
		w.value    = val[VALUE_W-1:0];
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		item_ch.valid <= 1'b1;
		item_ch.data  <= w;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		mirror.note_action(w);
		words_sent++;
	endtask

	// Drop valid and wait until every expected result word has come back.
	task automatic wait_drained();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		burst_left = 0;
		while (mirror.expected_results.size() != 0) @(posedge clk);
	endtask

	// Mostly in-range values, now and then any 20-bit pattern.
	function automatic int rand_value();
		if ($urandom_range(0, 15) == 0) return $urandom_range(0, 20'hFFFFF);
		return $urandom_range(0, 999999);
	endfunction

	initial begin
		int len;
		int pick;
		int p;
		int y;
		int n;
		int rand_base;
		bit pressed;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		pressed         = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty list, edges of the fields, every action and each corner.
		send_action(ACT_READ, 0, 0, 0);             // read from an empty list
		send_action(ACT_DELETE, 0, 0, 0);           // delete nothing
		send_action(ACT_DELETE, 1, 5, 0);           // delete past the end
		send_action(ACT_INSERT, 1, 0, 7);           // insert past the end
		send_action(ACT_INSERT, 0, 0, 999999);
		send_action(ACT_INSERT, 0, 0, 0);
		send_action(ACT_INSERT, 2, 0, 'hFFFFF);     // value above range, at the tail
		send_action(ACT_INSERT, 1, 0, 12345);       // into the middle
		send_action(ACT_APPEND, 0, 0, 'h55555);
		send_action(ACT_APPEND, 0, 0, 'hAAAAA);
		for (int i = 0; i < 6; i++)
			send_action(ACT_READ, i, 0, 0);
		send_action(ACT_READ, ALL_ONES, 0, 0);      // read far past the end
		send_action(ACT_DELETE, 1, 2, 0);           // remove from the middle
		send_action(ACT_DELETE, 3, ALL_ONES, 0);    // count runs past the tail
		send_action(ACT_DELETE, 3, 9, 0);           // position at the tail removes nothing
		send_action(ACT_DELETE, ALL_ONES, 1, 0);
		send_action(ACT_INSERT, ALL_ONES, 0, 1);
		for (int i = 0; i < 3; i++)
			send_action(ACT_READ, i, 0, 0);

		// Random: mostly well-formed insert runs, deletes and reads on a short list,
		// with some fully random noise words.
		gap_max   = 6;
		rand_base = words_sent;
		while (words_sent - rand_base < ITEMS) begin
			if (!pressed && words_sent - rand_base >= ITEMS / 3) begin
				pressed = 1'b1;
				// Pause the sender until the block is empty, then hold the receiver off
				// while words keep coming so the block backs up onto its input.
				wait_drained();
				gap_max     = 0;
				hold_cycles = 400;
				for (int i = 0; i < 24; i++) begin
					if (i % 3 == 0)
						send_action(ACT_APPEND, 0, 0, rand_value());
					else
						send_action(ACT_READ, $urandom_range(0, mirror.elems.size()), 0, 0);
				end
				gap_max = 6;
			end
			len  = mirror.elems.size();
			pick = $urandom_range(0, 99);
			if (len >= 56 && pick < 42)
				pick = 50;  // keep the list short: trade growth for a delete
			if (pick < 30) begin
				// run of inserts at consecutive positions
				p = $urandom_range(0, len);
				y = $urandom_range(1, 6);
				for (int k = 0; k < y; k++)
					send_action(ACT_INSERT, p + k, 0, rand_value());
			end else if (pick < 42) begin
				send_action(ACT_APPEND, 0, 0, rand_value());
			end else if (pick < 62) begin
				p = $urandom_range(0, len + 1);
				n = ($urandom_range(0, 9) == 0) ? ALL_ONES : $urandom_range(0, 4);
				send_action(ACT_DELETE, p, n, 0);
			end else if (pick < 88) begin
				send_action(ACT_READ, $urandom_range(0, len + 2), 0, 0);
			end else begin
				send_action(act_t'($urandom_range(0, 3)), $urandom_range(0, ALL_ONES),
					$urandom_range(0, ALL_ONES), $urandom_range(0, 20'hFFFFF));
			end
		end

		// Drain, then give any stray word time to show up.
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mirror.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#10ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sequence_insert_delete_buffer_core.f =====
sv/sidb_pkg.sv
sv/sidb_in_if.sv
sv/sidb_out_if.sv
sv/sidb_ctrl.sv
sv/sidb_dpath.sv
sv/sequence_insert_delete_buffer_core.sv
bench/sidb_bench_pkg.sv
bench/tb.sv
